/* rtl/core/mkit_pkg.sv */
package mkit_pkg;

  // defaults and fixed field widths
  localparam int unsigned TableEntriesDef = 32;
  localparam int unsigned KeySlotsDef     = 4;
  localparam int unsigned ResultLimit     = 32;
  localparam int unsigned KeyW            = 64;
  localparam int unsigned MaskW           = 4;
  localparam int unsigned StatusW         = 2;
  localparam int unsigned IndexOutW       = 5;
  localparam int unsigned FreeOutW        = 6;

  typedef enum logic [1:0] {
    ACT_INSERT,
    ACT_FIND,
    ACT_MATCH_ALL,
    ACT_CLEAR
  } action_e;

  typedef enum logic [1:0] {
    STS_OK,
    STS_FULL,
    STS_INVALID,
    STS_NO_MATCH
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FLUSH
  } fsm_e;

  // head entry compare result
  typedef struct packed {
    logic active;
    logic hit;
  } cmp_res_t;

endpackage

/* rtl/core/mkit_cell.sv */
// One table entry; shifts to its neighbor when the ring rotates.
module mkit_cell #(
  parameter int unsigned EntryW = 324
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              shift_i,
  input  logic [EntryW-1:0] entry_i,
  output logic [EntryW-1:0] entry_o
);

  logic [EntryW-1:0] entry_q;
  logic [EntryW-1:0] entry_d;

  always_comb begin
    entry_d = entry_q;
    if (clr_i) begin
      entry_d = '0;
    end else if (shift_i) begin
      entry_d = entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

/* rtl/core/mkit_cmp.sv */
// Pattern compare against the entry at the head of the ring.
// Entry layout: mask at the bottom, then state, then subkeys by slot.
module mkit_cmp #(
  parameter int unsigned KEY_SLOTS = mkit_pkg::KeySlotsDef,
  parameter int unsigned EntryW    = mkit_pkg::MaskW + mkit_pkg::KeyW * (KEY_SLOTS + 1)
) (
  input  logic [EntryW-1:0]                     entry_i,
  input  logic [mkit_pkg::MaskW-1:0]            pat_mask_i,
  input  logic [KEY_SLOTS*mkit_pkg::KeyW-1:0]   pat_keys_i,
  output mkit_pkg::cmp_res_t                    res_o
);

  localparam int unsigned KeyBase = mkit_pkg::MaskW + mkit_pkg::KeyW;

  logic [mkit_pkg::MaskW-1:0] ent_mask;
  logic [mkit_pkg::KeyW-1:0]  ent_state;
  logic                       keys_eq;

  assign ent_mask  = entry_i[mkit_pkg::MaskW-1:0];
  assign ent_state = entry_i[mkit_pkg::MaskW +: mkit_pkg::KeyW];

  always_comb begin
    keys_eq = 1'b1;
    for (int unsigned s = 0; s < KEY_SLOTS; s++) begin
      if (pat_mask_i[s] &&
          (pat_keys_i[s*mkit_pkg::KeyW +: mkit_pkg::KeyW] !=
           entry_i[KeyBase + s*mkit_pkg::KeyW +: mkit_pkg::KeyW])) begin
        keys_eq = 1'b0;
      end
    end
  end

  always_comb begin
    res_o.active = (|ent_mask) || (|ent_state);
    // pattern mask must be a subset of the entry mask
    res_o.hit    = ((pat_mask_i & ~ent_mask) == '0) && keys_eq;
  end

endmodule

/* rtl/core/masked_key_instance_table_core.sv */
// Channel   | Handshake            | Payload
// ----------+----------------------+----------------------------------------------
// request   | start / busy         | action_i, key_mask_i, key_0_i..key_3_i,
//           |                      | new_state_i
// result    | result_strobe_o      | status_o, entry_index_o, entry_state_o,
//           |                      | free_count_o, last_o
//
// A request word is taken at a clock edge with start high and busy low.
// Insert, find, match-all: one ring rotation at one entry per cycle through the head
// compare, then a flush; clear: the flush state alone.
// Result words leave a register, one strobed cycle each; the receiver cannot stall.
// The last word shows in the first cycle with busy low, beside a possible accept.
// Reset (rst_ni, async, low) zeroes every entry and sets the free count to TABLE_ENTRIES.
module masked_key_instance_table_core #(
  parameter int unsigned TABLE_ENTRIES = mkit_pkg::TableEntriesDef,
  parameter int unsigned KEY_SLOTS     = mkit_pkg::KeySlotsDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          action_i,
  input  logic [mkit_pkg::MaskW-1:0]          key_mask_i,
  input  logic [mkit_pkg::KeyW-1:0]           key_0_i,
  input  logic [mkit_pkg::KeyW-1:0]           key_1_i,
  input  logic [mkit_pkg::KeyW-1:0]           key_2_i,
  input  logic [mkit_pkg::KeyW-1:0]           key_3_i,
  input  logic [mkit_pkg::KeyW-1:0]           new_state_i,
  // result
  output logic                                result_strobe_o,
  output logic [mkit_pkg::StatusW-1:0]        status_o,
  output logic [mkit_pkg::IndexOutW-1:0]      entry_index_o,
  output logic [mkit_pkg::KeyW-1:0]           entry_state_o,
  output logic [mkit_pkg::FreeOutW-1:0]       free_count_o,
  output logic                                last_o
);

  localparam int unsigned KeyW    = mkit_pkg::KeyW;
  localparam int unsigned MaskW   = mkit_pkg::MaskW;
  localparam int unsigned KeysW   = KEY_SLOTS * KeyW;
  localparam int unsigned EntryW  = MaskW + KeyW + KeysW;
  localparam int unsigned IdxW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned FreeW   = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CntW    = $clog2(mkit_pkg::ResultLimit + 1);

  // ---------------------------------------------------------------------------
  // Request capture
  // ---------------------------------------------------------------------------
  logic                          accept;
  mkit_pkg::action_e             req_act_q;
  logic [MaskW-1:0]              req_mask_q;
  logic [KeysW-1:0]              req_keys_q;
  logic [KeyW-1:0]               req_state_q;
  logic                          req_invalid_q;
  logic                          req_room_q;
  logic [4*KeyW-1:0]             keys_all;

  assign keys_all = {key_3_i, key_2_i, key_1_i, key_0_i};
  assign accept   = start && !busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_act_q     <= mkit_pkg::action_e'(action_i);
      req_mask_q    <= key_mask_i;
      req_keys_q    <= keys_all[KeysW-1:0];
      req_state_q   <= new_state_i;
      req_invalid_q <= (new_state_i == '0) && (key_mask_i == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  mkit_pkg::fsm_e fsm_q, fsm_d;
  logic [IdxW-1:0] scan_q;
  logic            scan_end;

  assign scan_end = (scan_q == IdxW'(TABLE_ENTRIES - 1));

  always_comb begin
    fsm_d = fsm_q;
    case (fsm_q)
      mkit_pkg::FSM_IDLE: begin
        if (accept) begin
          fsm_d = (mkit_pkg::action_e'(action_i) == mkit_pkg::ACT_CLEAR) ?
                  mkit_pkg::FSM_FLUSH : mkit_pkg::FSM_SCAN;
        end
      end
      mkit_pkg::FSM_SCAN: begin
        if (scan_end) begin
          fsm_d = mkit_pkg::FSM_FLUSH;
        end
      end
      mkit_pkg::FSM_FLUSH: begin
        fsm_d = mkit_pkg::FSM_IDLE;
      end
      default: begin
        fsm_d = mkit_pkg::FSM_IDLE;
      end
    endcase
  end

  assign busy = (fsm_q != mkit_pkg::FSM_IDLE);

  // ---------------------------------------------------------------------------
  // Entry ring: cell 0 is the head, the ring rotates once per scan cycle so
  // entry k sits at the head in scan cycle k and the ring ends aligned.
  // ---------------------------------------------------------------------------
  logic [EntryW-1:0]  ring_q [TABLE_ENTRIES];
  logic [EntryW-1:0]  ring_d [TABLE_ENTRIES];
  logic [EntryW-1:0]  tail_d;
  logic [EntryW-1:0]  new_entry;
  logic               ring_shift;
  logic               ring_clr;
  mkit_pkg::cmp_res_t head_res;
  logic               ins_now;

  assign ring_shift = (fsm_q == mkit_pkg::FSM_SCAN);
  assign ring_clr   = accept && (mkit_pkg::action_e'(action_i) == mkit_pkg::ACT_CLEAR);
  assign new_entry  = {req_keys_q, req_state_q, req_mask_q};

  for (genvar gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_ring
    if (gi == TABLE_ENTRIES - 1) begin : g_tail
      assign ring_d[gi] = tail_d;
    end else begin : g_link
      assign ring_d[gi] = ring_q[gi+1];
    end
    mkit_cell #(
      .EntryW (EntryW)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (ring_clr),
      .shift_i (ring_shift),
      .entry_i (ring_d[gi]),
      .entry_o (ring_q[gi])
    );
  end

  mkit_cmp #(
    .KEY_SLOTS (KEY_SLOTS),
    .EntryW    (EntryW)
  ) u_cmp (
    .entry_i    (ring_q[0]),
    .pat_mask_i (req_mask_q),
    .pat_keys_i (req_keys_q),
    .res_o      (head_res)
  );

  // ---------------------------------------------------------------------------
  // Hit tracking. hit_* holds the insert target, the first find hit, or the
  // match-all word still waiting to learn whether it is the last one.
  // ---------------------------------------------------------------------------
  logic             hit_q;
  logic [IdxW-1:0]  hit_idx_q;
  logic [KeyW-1:0]  hit_state_q;
  logic [CntW-1:0]  count_q;
  logic [FreeW-1:0] free_q;
  logic             find_now;
  logic             all_now;

  // first inactive entry takes the insert
  assign ins_now  = ring_shift && (req_act_q == mkit_pkg::ACT_INSERT) && req_room_q &&
                    !hit_q && !head_res.active;
  // inactive entries count for find
  assign find_now = ring_shift && (req_act_q == mkit_pkg::ACT_FIND) && !hit_q &&
                    head_res.hit;
  assign all_now  = ring_shift && (req_act_q == mkit_pkg::ACT_MATCH_ALL) &&
                    head_res.active && head_res.hit &&
                    (count_q < CntW'(mkit_pkg::ResultLimit));
  assign tail_d   = ins_now ? new_entry : ring_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q      <= mkit_pkg::FSM_IDLE;
      scan_q     <= '0;
      hit_q      <= 1'b0;
      count_q    <= '0;
      req_room_q <= 1'b0;
      free_q     <= FreeW'(TABLE_ENTRIES);
    end else begin
      fsm_q <= fsm_d;
      if (accept) begin
        scan_q     <= '0;
        hit_q      <= 1'b0;
        count_q    <= '0;
        req_room_q <= (free_q != '0) && !((new_state_i == '0) && (key_mask_i == '0));
        if (ring_clr) begin
          free_q <= FreeW'(TABLE_ENTRIES);
        end
      end else if (ring_shift) begin
        scan_q <= scan_q + IdxW'(1);
        if (ins_now) begin
          hit_q  <= 1'b1;
          free_q <= free_q - FreeW'(1);
        end
        if (find_now || all_now) begin
          hit_q <= 1'b1;
        end
        if (all_now) begin
          count_q <= count_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ins_now) begin
      hit_idx_q   <= scan_q;
      hit_state_q <= req_state_q;
    end else if (find_now || all_now) begin
      hit_idx_q   <= scan_q;
      hit_state_q <= ring_q[0][MaskW +: KeyW];
    end
  end

  // ---------------------------------------------------------------------------
  // Result word selection
  // ---------------------------------------------------------------------------
  logic                          emit_vld;
  mkit_pkg::status_e             emit_status;
  logic                          emit_use_hit;
  logic                          emit_last;
  logic [IdxW+mkit_pkg::IndexOutW-1:0] hit_idx_ext;
  logic [FreeW+mkit_pkg::FreeOutW-1:0] free_ext;

  assign hit_idx_ext = {{mkit_pkg::IndexOutW{1'b0}}, hit_idx_q};
  assign free_ext    = {{mkit_pkg::FreeOutW{1'b0}}, free_q};

  always_comb begin
    emit_vld     = 1'b0;
    emit_status  = mkit_pkg::STS_OK;
    emit_use_hit = 1'b0;
    emit_last    = 1'b1;
    case (fsm_q)
      mkit_pkg::FSM_SCAN: begin
        // a newer match releases the pending one as a non-final word
        if (all_now && hit_q) begin
          emit_vld     = 1'b1;
          emit_use_hit = 1'b1;
          emit_last    = 1'b0;
        end
      end
      mkit_pkg::FSM_FLUSH: begin
        emit_vld = 1'b1;
        case (req_act_q)
          mkit_pkg::ACT_INSERT: begin
            if (req_invalid_q) begin
              emit_status = mkit_pkg::STS_INVALID;
            end else if (!hit_q) begin
              emit_status = mkit_pkg::STS_FULL;
            end else begin
              emit_use_hit = 1'b1;
            end
          end
          mkit_pkg::ACT_FIND, mkit_pkg::ACT_MATCH_ALL: begin
            if (hit_q) begin
              emit_use_hit = 1'b1;
            end else begin
              emit_status = mkit_pkg::STS_NO_MATCH;
            end
          end
          default: begin
            emit_status = mkit_pkg::STS_OK;
          end
        endcase
      end
      default: begin
        emit_vld = 1'b0;
      end
    endcase
  end

  // result register
  logic                            res_vld_q;
  logic [mkit_pkg::StatusW-1:0]    res_status_q;
  logic [mkit_pkg::IndexOutW-1:0]  res_idx_q;
  logic [KeyW-1:0]                 res_state_q;
  logic [mkit_pkg::FreeOutW-1:0]   res_free_q;
  logic                            res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else begin
      res_vld_q <= emit_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_vld) begin
      res_status_q <= emit_status;
      res_idx_q    <= emit_use_hit ? hit_idx_ext[mkit_pkg::IndexOutW-1:0] : '0;
      res_state_q  <= emit_use_hit ? hit_state_q : '0;
      res_free_q   <= free_ext[mkit_pkg::FreeOutW-1:0];
      res_last_q   <= emit_last;
    end
  end

  assign result_strobe_o = res_vld_q;
  assign status_o        = res_status_q;
  assign entry_index_o   = res_idx_q;
  assign entry_state_o   = res_state_q;
  assign free_count_o    = res_free_q;
  assign last_o          = res_last_q;

endmodule
